[rtl/core/score_sort_class_nms_assert.svh]
// Assertion macros for the NMS block.
`ifndef SCORE_SORT_CLASS_NMS_ASSERT_SVH
`define SCORE_SORT_CLASS_NMS_ASSERT_SVH
`ifndef SYNTH
`define NMS_ASSERT_IMP(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);
`define NMS_ASSERT_NXT(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);
`else
`define NMS_ASSERT_IMP(label, clk, rst, a, c, msg)
`define NMS_ASSERT_NXT(label, clk, rst, a, c, msg)
`endif
`endif

[rtl/core/ssnms_pkg.sv]
// ----------------------------------------------------------------------------
// ssnms_pkg
// Shared constants and types for the score-sorted per-class NMS block.
// ----------------------------------------------------------------------------
`default_nettype none
package ssnms_pkg;
  localparam int MAX_BOXES = 64;
  localparam int IDX_W = $clog2(MAX_BOXES);
  localparam int CNT_W = $clog2(MAX_BOXES + 1);
  localparam logic [15:0] THR_RESET = 16'd29491;
  localparam logic [6:0] MAXDET_RESET = 7'd64;
  localparam logic [1:0] REG_THRESHOLD = 2'd0;
  localparam logic [1:0] REG_MAX_DET = 2'd1;
  localparam logic [5:0] PIX_ONE = 6'd16;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [14:0] w;
    logic [14:0] h;
    logic [6:0] class_id;
    logic [15:0] score;
    logic last;
  } box_t;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [14:0] w;
    logic [14:0] h;
    logic [6:0] class_id;
    logic [15:0] score;
    logic last;
  } det_t;

  typedef struct packed {
    logic [1:0] index;
    logic [15:0] data;
  } cfg_t;
endpackage
`default_nettype wire

[rtl/core/ssnms_if.sv]
// ----------------------------------------------------------------------------
// ssnms_box_if / ssnms_det_if / ssnms_cfg_if
// Valid/ready channels of the NMS block.
// ----------------------------------------------------------------------------
`default_nettype none
interface ssnms_box_if;
  logic valid;
  logic ready;
  ssnms_pkg::box_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ssnms_det_if;
  logic valid;
  logic ready;
  ssnms_pkg::det_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ssnms_cfg_if;
  logic valid;
  logic ready;
  ssnms_pkg::cfg_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

[rtl/core/score_sort_class_nms.sv]
// Greedy per-class NMS. Boxes load one word per cycle until the last-marked
// word; the input is then not ready until emission of the frame ends. Both
// tables are read through registered ports, one address each per cycle, so
// every fetch returns registered data. Sort: each box's score is fetched as
// the key, then the sorted entries above it are fetched and shifted down one
// at a time until one scores at least as high or the top is reached. Pairwise
// pass, per sorted position: skip it if already suppressed, else fetch it,
// then per later position skip it if suppressed, fetch it, skip another class,
// and for the same class run six IoU steps, three on the shared multiplier.
// Emission: suppressed positions are skipped; each kept box, up to
// max_detections, is fetched and held on the output until it is taken.
// ----------------------------------------------------------------------------
// score_sort_class_nms
// Score sort and per-class greedy IoU suppression of one frame of boxes.
// ----------------------------------------------------------------------------
`default_nettype none
`include "score_sort_class_nms_assert.svh"
module score_sort_class_nms (
  input wire logic clk,
  input wire logic rst,
  ssnms_box_if.sink in_box,
  ssnms_cfg_if.sink cfg,
  ssnms_det_if.source out_det
);
  import ssnms_pkg::*;

  typedef enum logic [16:0] {
    S_LOAD    = 17'b00000000000000001,
    S_SORT_A  = 17'b00000000000000010,
    S_SORT_K  = 17'b00000000000000100,
    S_SORT_RD = 17'b00000000000001000,
    S_SORT_B  = 17'b00000000000010000,
    S_SORT_C  = 17'b00000000000100000,
    S_NMS_I   = 17'b00000000001000000,
    S_NMS_IA  = 17'b00000000010000000,
    S_NMS_IB  = 17'b00000000100000000,
    S_NMS_J   = 17'b00000001000000000,
    S_NMS_JA  = 17'b00000010000000000,
    S_NMS_RD  = 17'b00000100000000000,
    S_IOU     = 17'b00001000000000000,
    S_EMIT_A  = 17'b00010000000000000,
    S_EMIT_R  = 17'b00100000000000000,
    S_EMIT_B  = 17'b01000000000000000,
    S_OUT     = 17'b10000000000000000
  } state_t;

  state_t state;

  box_t box_mem [MAX_BOXES];
  logic [IDX_W-1:0] order_mem [MAX_BOXES];
  logic [MAX_BOXES-1:0] suppressed;
  logic [CNT_W-1:0] box_count;
  logic [15:0] nms_threshold;
  logic [6:0] max_detections;

  logic [CNT_W-1:0] k, pos, i, j, emitted;
  box_t a_box, b_box, box_q;
  logic [15:0] key;
  logic [IDX_W-1:0] ord_addr, ord_q, box_addr;
  logic [2:0] phase;
  logic [31:0] inter;
  logic [33:0] uni;
  logic [31:0] prod_a, prod_b;
  logic [50:0] lhs;

  assign in_box.ready = (state == S_LOAD);
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      nms_threshold <= THR_RESET;
      max_detections <= MAXDET_RESET;
    end else if (cfg.valid) begin
      case (cfg.data.index)
        REG_THRESHOLD: nms_threshold <= cfg.data.data;
        REG_MAX_DET: max_detections <= cfg.data.data[6:0];
        default: begin
        end
      endcase
    end
  end

  // intersection extents, signed 18 bit
  logic signed [17:0] ax1, bx1, ay1, by1, ix, iy;
  logic [16:0] iw, ih;
  always_comb begin
    ax1 = 18'(a_box.x) + 18'(signed'({1'b0, a_box.w}));
    bx1 = 18'(b_box.x) + 18'(signed'({1'b0, b_box.w}));
    ay1 = 18'(a_box.y) + 18'(signed'({1'b0, a_box.h}));
    by1 = 18'(b_box.y) + 18'(signed'({1'b0, b_box.h}));
    ix = ((ax1 < bx1) ? ax1 : bx1) - ((a_box.x > b_box.x) ? 18'(a_box.x) : 18'(b_box.x))
         + 18'(PIX_ONE);
    iy = ((ay1 < by1) ? ay1 : by1) - ((a_box.y > b_box.y) ? 18'(a_box.y) : 18'(b_box.y))
         + 18'(PIX_ONE);
    iw = ix[17] ? 17'd0 : ix[16:0];
    ih = iy[17] ? 17'd0 : iy[16:0];
  end

  // shared multiplier: 17x17 operands selected by phase
  logic [16:0] m_a, m_b;
  logic [33:0] m_p;
  always_comb begin
    case (phase)
      3'd0: begin m_a = iw; m_b = ih; end
      3'd1: begin m_a = {2'b0, a_box.w} + 17'(PIX_ONE); m_b = {2'b0, a_box.h} + 17'(PIX_ONE); end
      default: begin
        m_a = {2'b0, b_box.w} + 17'(PIX_ONE); m_b = {2'b0, b_box.h} + 17'(PIX_ONE);
      end
    endcase
    m_p = m_a * m_b;
  end

  // table read addresses, read data is registered
  always_comb begin
    case (state)
      S_SORT_K, S_SORT_RD, S_SORT_B: ord_addr = IDX_W'(pos - 1'b1);
      S_NMS_I, S_EMIT_A: ord_addr = i[IDX_W-1:0];
      S_NMS_J: ord_addr = j[IDX_W-1:0];
      default: ord_addr = '0;
    endcase
    case (state)
      S_SORT_A: box_addr = k[IDX_W-1:0];
      S_SORT_B, S_NMS_IA, S_NMS_JA, S_EMIT_R: box_addr = ord_q;
      default: box_addr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    ord_q <= order_mem[ord_addr];
    box_q <= box_mem[box_addr];
  end

  // later survivors still waiting behind sorted position i
  logic [MAX_BOXES-1:0] rest;
  always_comb begin
    for (int q = 0; q < MAX_BOXES; q++)
      rest[q] = (CNT_W'(q) > i) && (CNT_W'(q) < box_count) && !suppressed[q];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      box_count <= '0;
      suppressed <= '0;
      out_det.valid <= 1'b0;
      phase <= '0;
    end else begin
      case (state)
        S_LOAD: begin
          if (in_box.valid) begin
            if (box_count < CNT_W'(MAX_BOXES)) begin
              box_mem[box_count[IDX_W-1:0]] <= in_box.data;
              box_count <= box_count + 1'b1;
            end
            if (in_box.data.last) begin
              k <= '0;
              state <= S_SORT_A;
            end
          end
        end
        S_SORT_A: begin
          if (k == box_count) begin
            i <= '0;
            suppressed <= '0;
            state <= S_NMS_I;
          end else begin
            pos <= k;
            state <= S_SORT_K;
          end
        end
        S_SORT_K: begin
          key <= box_q.score;
          state <= S_SORT_B;
        end
        S_SORT_RD: begin
          state <= S_SORT_B;
        end
        S_SORT_B: begin
          if (pos == '0) begin
            order_mem[pos[IDX_W-1:0]] <= k[IDX_W-1:0];
            k <= k + 1'b1;
            state <= S_SORT_A;
          end else begin
            state <= S_SORT_C;
          end
        end
        S_SORT_C: begin
          // one insertion step: compare with entry above
          if (box_q.score < key) begin
            order_mem[pos[IDX_W-1:0]] <= ord_q;
            pos <= pos - 1'b1;
            state <= S_SORT_RD;
          end else begin
            order_mem[pos[IDX_W-1:0]] <= k[IDX_W-1:0];
            k <= k + 1'b1;
            state <= S_SORT_A;
          end
        end
        S_NMS_I: begin
          if (i == box_count) begin
            i <= '0;
            emitted <= '0;
            state <= S_EMIT_A;
          end else if (suppressed[i[IDX_W-1:0]]) begin
            i <= i + 1'b1;
          end else begin
            state <= S_NMS_IA;
          end
        end
        S_NMS_IA: begin
          state <= S_NMS_IB;
        end
        S_NMS_IB: begin
          a_box <= box_q;
          j <= i + 1'b1;
          state <= S_NMS_J;
        end
        S_NMS_J: begin
          if (j == box_count) begin
            i <= i + 1'b1;
            state <= S_NMS_I;
          end else if (suppressed[j[IDX_W-1:0]]) begin
            j <= j + 1'b1;
          end else begin
            state <= S_NMS_JA;
          end
        end
        S_NMS_JA: begin
          state <= S_NMS_RD;
        end
        S_NMS_RD: begin
          b_box <= box_q;
          phase <= '0;
          if (box_q.class_id != a_box.class_id) begin
            j <= j + 1'b1;
            state <= S_NMS_J;
          end else begin
            state <= S_IOU;
          end
        end
        S_IOU: begin
          phase <= phase + 1'b1;
          case (phase)
            3'd0: inter <= m_p[31:0];
            3'd1: prod_a <= m_p[31:0];
            3'd2: prod_b <= m_p[31:0];
            3'd3: uni <= 34'(prod_a) + 34'(prod_b) - 34'(inter);
            3'd4: lhs <= 51'(nms_threshold) * 51'(uni[33:0]);
            default: begin
              if ({inter, 16'h0} > 48'(lhs) && lhs[50:48] == 3'b0)
                suppressed[j[IDX_W-1:0]] <= 1'b1;
              j <= j + 1'b1;
              state <= S_NMS_J;
            end
          endcase
        end
        S_EMIT_A: begin
          if (i == box_count || emitted == CNT_W'(max_detections)) begin
            box_count <= '0;
            suppressed <= '0;
            state <= S_LOAD;
          end else if (suppressed[i[IDX_W-1:0]]) begin
            i <= i + 1'b1;
          end else begin
            state <= S_EMIT_R;
          end
        end
        S_EMIT_R: begin
          state <= S_EMIT_B;
        end
        S_EMIT_B: begin
          out_det.data.x <= box_q.x;
          out_det.data.y <= box_q.y;
          out_det.data.w <= box_q.w;
          out_det.data.h <= box_q.h;
          out_det.data.class_id <= box_q.class_id;
          out_det.data.score <= box_q.score;
          out_det.data.last <= (rest == '0) || ((emitted + 1'b1) == CNT_W'(max_detections));
          out_det.valid <= 1'b1;
          emitted <= emitted + 1'b1;
          i <= i + 1'b1;
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_det.ready) begin
            out_det.valid <= 1'b0;
            state <= S_EMIT_A;
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

  `NMS_ASSERT_IMP(a_ready_load, clk, rst, in_box.ready, state == S_LOAD, "ready outside load")
  `NMS_ASSERT_IMP(a_cnt_max, clk, rst, 1'b1, box_count <= CNT_W'(MAX_BOXES), "count overflow")
  `NMS_ASSERT_NXT(a_hold, clk, rst, out_det.valid && !out_det.ready,
                  out_det.valid, "detection dropped")
endmodule
`default_nettype wire
